@@ hw/rtl/smm_pkg.sv @@
// Shared types and constants for the square int32 matrix multiplier.
package smm_pkg;

   // Field widths fixed by the interface.
   localparam int OP_W   = 2;
   localparam int IDX_W  = 6;
   localparam int DATA_W = 32;
   localparam int DIM_W  = 4;

   // Operation codes carried on req_op.
   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

   // Side length after reset.
   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             wr_a;
      logic             wr_b;
      logic [IDX_W-1:0] wr_addr;
      logic             rd_valid;
      logic             rd_first;
      logic             rd_last;
      logic [IDX_W-1:0] a_addr;
      logic [IDX_W-1:0] b_addr;
      logic [IDX_W-1:0] pos;
      logic             last_elem;
   } smm_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic rsp_taken;
      logic pipe_busy;
   } smm_sts_type;

endpackage

@@ hw/rtl/square_int32_matrix_multiply.sv @@
// Top level of the square signed 32-bit matrix multiplier.
//
//   Channel   Direction  Handshake                Payload
//   req       in         req_valid / req_ready    op, element_index, element_value
//   rsp       out        rsp_valid / rsp_ready    product_index, product_value, last
//   csr       in         csr_write_enable         csr_write_data (side length)
//
// A load transaction writes one element of A or B.
// A run transaction computes the elements of C one after another on the one shared
// multiply-accumulate: n read pairs pass the read and multiply registers into the
// accumulator, and the result is handed over before the next element is started.
// No input transaction is taken while a run is in progress; a stalled rsp_ready
// holds the run. Reset clears control state only; the matrix stores are not cleared.
module square_int32_matrix_multiply #(
   parameter int MAX_DIM = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [smm_pkg::OP_W-1:0]          req_op,
   input  logic [smm_pkg::IDX_W-1:0]         req_element_index,
   input  logic signed [smm_pkg::DATA_W-1:0] req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [smm_pkg::IDX_W-1:0]         rsp_product_index,
   output logic signed [smm_pkg::DATA_W-1:0] rsp_product_value,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [smm_pkg::DIM_W-1:0]         csr_write_data
);
   import smm_pkg::*;

   smm_cmd_type cmd;
   smm_sts_type sts;

   // Sequencer and configuration.
   smm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_element_index (req_element_index),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .sts               (sts)
   );

   // Storage, arithmetic and result register.
   smm_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .wr_data           (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_product_index (rsp_product_index),
      .rsp_product_value (rsp_product_value),
      .rsp_last          (rsp_last)
   );

endmodule

@@ hw/rtl/smm_ctrl.sv @@
// Controller: dimension register, load decode and the run sequencer over i, j and k.
module smm_ctrl #(
   parameter int MAX_DIM = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [smm_pkg::OP_W-1:0]     req_op,
   input  logic [smm_pkg::IDX_W-1:0]    req_element_index,
   input  logic                         csr_write_enable,
   input  logic [smm_pkg::DIM_W-1:0]    csr_write_data,
   output smm_pkg::smm_cmd_type         cmd,
   input  smm_pkg::smm_sts_type         sts
);
   import smm_pkg::*;

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [DIM_W-1:0] dim_ff;
   logic [DIM_W-1:0] n_ff, n_in;
   logic [DIM_W-1:0] row_i_ff, row_i_in;
   logic [DIM_W-1:0] col_j_ff, col_j_in;
   logic [DIM_W-1:0] t_ff, t_in;
   logic [IDX_W-1:0] row_base_ff, row_base_in;
   logic [IDX_W-1:0] col_addr_ff, col_addr_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [DIM_W-1:0] n_sat;
   logic [DIM_W-1:0] n_last;
   logic [DIM_W-1:0] col_j_next;
   logic [IDX_W-1:0] n_wide;
   logic             last_elem;
   logic             load_ok;
   logic             req_fire;

   // Dimension register, written whenever the enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_write_enable) begin
         dim_ff <= csr_write_data;
      end
   end

   // Clamp the configured side into 1..MAX_DIM.
   always_comb begin
      if (dim_ff == '0) begin
         n_sat = DIM_W'(1);
      end else if (dim_ff > DIM_W'(MAX_DIM)) begin
         n_sat = DIM_W'(MAX_DIM);
      end else begin
         n_sat = dim_ff;
      end
   end

   assign n_last     = n_ff - DIM_W'(1);
   assign n_wide     = IDX_W'(n_ff);
   assign col_j_next = col_j_ff + DIM_W'(1);
   assign last_elem  = (row_i_ff == n_last) && (col_j_ff == n_last);

   // Input transactions are taken only while no run is in progress.
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign load_ok   = ({1'b0, req_element_index} < (IDX_W + 1)'(STORE_DEPTH));

   // Sequencer: one read pair per cycle for each dot product, then wait for delivery.
   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      row_i_in    = row_i_ff;
      col_j_in    = col_j_ff;
      t_in        = t_ff;
      row_base_in = row_base_ff;
      col_addr_in = col_addr_ff;
      pos_in      = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_op == OP_RUN)) begin
               n_in        = n_sat;
               row_i_in    = '0;
               col_j_in    = '0;
               t_in        = '0;
               row_base_in = '0;
               col_addr_in = '0;
               pos_in      = '0;
               state_in    = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            t_in        = t_ff + DIM_W'(1);
            col_addr_in = col_addr_ff + n_wide;
            if (t_ff == n_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sts.rsp_taken) begin
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  t_in     = '0;
                  pos_in   = pos_ff + IDX_W'(1);
                  state_in = ST_ISSUE;
                  if (col_j_ff == n_last) begin
                     col_j_in    = '0;
                     row_i_in    = row_i_ff + DIM_W'(1);
                     row_base_in = row_base_ff + n_wide;
                     col_addr_in = '0;
                  end else begin
                     col_j_in    = col_j_next;
                     col_addr_in = IDX_W'(col_j_next);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Loop counters and addresses; only meaningful during a run.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      row_i_ff    <= row_i_in;
      col_j_ff    <= col_j_in;
      t_ff        <= t_in;
      row_base_ff <= row_base_in;
      col_addr_ff <= col_addr_in;
      pos_ff      <= pos_in;
   end

   // Commands to the datapath.
   always_comb begin
      cmd.wr_a      = req_fire && (req_op == OP_LOAD_A) && load_ok;
      cmd.wr_b      = req_fire && (req_op == OP_LOAD_B) && load_ok;
      cmd.wr_addr   = req_element_index;
      cmd.rd_valid  = (state_ff == ST_ISSUE);
      cmd.rd_first  = (t_ff == '0);
      cmd.rd_last   = (t_ff == n_last);
      cmd.a_addr    = row_base_ff + IDX_W'(t_ff);
      cmd.b_addr    = col_addr_ff;
      cmd.pos       = pos_ff;
      cmd.last_elem = last_elem;
   end

   // A finished dot product is only handed over while the sequencer waits for it.
   a_taken_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.rsp_taken |-> (state_ff == ST_WAIT))
      else $error("result delivered outside the wait state");

   // Back in idle the multiply pipeline has drained.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !sts.pipe_busy)
      else $error("pipeline busy while idle");

endmodule

@@ hw/rtl/smm_datapath.sv @@
// Datapath: A and B storage, multiply-accumulate pipeline and the result register.
module smm_datapath #(
   parameter int MAX_DIM = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  smm_pkg::smm_cmd_type              cmd,
   output smm_pkg::smm_sts_type              sts,
   input  logic signed [smm_pkg::DATA_W-1:0] wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [smm_pkg::IDX_W-1:0]         rsp_product_index,
   output logic signed [smm_pkg::DATA_W-1:0] rsp_product_value,
   output logic                              rsp_last
);
   import smm_pkg::*;

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [DATA_W-1:0] mem_a [STORE_DEPTH];
   logic [DATA_W-1:0] mem_b [STORE_DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;
   logic [DATA_W-1:0] prod_ff;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] sum;
   logic              s1_valid_ff, s1_first_ff, s1_last_ff;
   logic              s2_valid_ff, s2_first_ff, s2_last_ff;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_last_ff;

   // Storage for A and B: one write port, registered reads.
   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[cmd.wr_addr[ADDR_W-1:0]] <= wr_data;
      end
      rd_a_ff <= mem_a[cmd.a_addr[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         mem_b[cmd.wr_addr[ADDR_W-1:0]] <= wr_data;
      end
      rd_b_ff <= mem_b[cmd.b_addr[ADDR_W-1:0]];
   end

   // Stage tags that travel alongside the read data and the product.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.rd_first;
      s1_last_ff  <= cmd.rd_last;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
   end

   // Multiply stage, wrapping to the low 32 bits.
   always_ff @(posedge clock) begin
      prod_ff <= rd_a_ff * rd_b_ff;
   end

   // Accumulate stage; the first term of a dot product restarts the sum.
   assign sum = (s2_first_ff ? '0 : acc_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff <= sum;
      end
   end

   // Result register: loaded with the finished sum, held until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_valid_ff && s2_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_last_ff) begin
         rsp_index_ff <= cmd.pos;
         rsp_value_ff <= sum;
         rsp_last_ff  <= cmd.last_elem;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_index = rsp_index_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

   assign sts.rsp_taken = rsp_valid_ff && rsp_ready;
   assign sts.pipe_busy = s1_valid_ff || s2_valid_ff;

   // A new sum never lands on a result that has not been delivered.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_last_ff) |-> !rsp_valid_ff)
      else $error("result register overwritten before delivery");

endmodule

@@ bench/square_int32_matrix_multiply_test.sv @@
// Self-checking testbench for the square signed 32-bit matrix multiplier.
module square_int32_matrix_multiply_test;
   timeunit 1ns;
   timeprecision 1ps;

   import smm_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int MAX_SIDE = 8;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 280;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT = 4000;
   localparam int IDLE_PERCENT = 30;
   localparam int PLAN_LENGTH = 14;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] value;
   } request_type;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] value;
      logic              last;
   } product_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_W-1:0]          req_op = OP_LOAD_A;
   logic [IDX_W-1:0]         req_element_index = '0;
   logic signed [DATA_W-1:0] req_element_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [IDX_W-1:0]         rsp_product_index;
   logic signed [DATA_W-1:0] rsp_product_value;
   logic                     rsp_last;
   logic                     csr_write_enable = 1'b0;
   logic [DIM_W-1:0]         csr_write_data = DIM_RESET;

   request_type       queued_requests[$];
   product_type       expected_products[$];
   request_type       next_request;
   product_type       wanted_product;
   logic [DATA_W-1:0] left_store [STORE_DEPTH];
   logic [DATA_W-1:0] right_store [STORE_DEPTH];
   logic [DIM_W-1:0]  active_dimension = DIM_RESET;
   bit [STORE_DEPTH-1:0] a_loaded = '0;
   bit [STORE_DEPTH-1:0] b_loaded = '0;
   bit                steady = 1'b0;
   int                mismatches = 0;
   int                quiet_cycles = 0;
   int                items_issued = 0;
   int                dim_plan [PLAN_LENGTH];

   square_int32_matrix_multiply #(
      .MAX_DIM(MAX_SIDE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_element_index(req_element_index),
      .req_element_value(req_element_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_product_index(rsp_product_index),
      .rsp_product_value(rsp_product_value),
      .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // Free-running clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Side length actually used: zero acts as one, large values saturate.
   function automatic int side_of(input logic [DIM_W-1:0] dim);
      if (dim == 0) return 1;
      if (dim > MAX_SIDE) return MAX_SIDE;
      return int'(dim);
   endfunction

   // Random element value with the signed extremes mixed in often.
   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Updates the matrix copies and queues every element of C for a run.
   task automatic predict_products(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                   input logic [DATA_W-1:0] val);
      int n;
      logic [DATA_W-1:0] acc;
      product_type element;
      case (op)
         OP_LOAD_A: left_store[idx] = val;
         OP_LOAD_B: right_store[idx] = val;
         OP_RUN: begin
            n = side_of(active_dimension);
            for (int r = 0; r < n; r++) begin
               for (int c = 0; c < n; c++) begin
                  acc = '0;
                  for (int t = 0; t < n; t++) begin
                     acc = acc + left_store[r*n+t] * right_store[t*n+c];
                  end
                  element.index = IDX_W'(r*n+c);
                  element.value = acc;
                  element.last = (r == n-1) && (c == n-1);
                  expected_products.push_back(element);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Queues one load of A or B and records the address as written.
   task automatic queue_load(input logic [OP_W-1:0] op, input int addr,
                             input logic [DATA_W-1:0] val);
      request_type item;
      item.op = op;
      item.index = addr[IDX_W-1:0];
      item.value = val;
      queued_requests.push_back(item);
      if (op == OP_LOAD_A) a_loaded[addr] = 1'b1;
      else b_loaded[addr] = 1'b1;
      items_issued++;
   endtask

   // Queues a run whose index and value fields carry random junk.
   task automatic queue_run();
      request_type item;
      item.op = OP_RUN;
      item.index = IDX_W'($urandom);
      item.value = $urandom;
      queued_requests.push_back(item);
      items_issued++;
   endtask

   // Queues an unused opcode that must leave the matrices untouched.
   task automatic queue_unused();
      request_type item;
      item.op = OP_UNUSED;
      item.index = IDX_W'($urandom);
      item.value = $urandom;
      queued_requests.push_back(item);
   endtask

   // True when every element a run of side n reads has been written.
   function automatic bit operands_ready(input int n);
      for (int a = 0; a < n*n; a++) begin
         if (!a_loaded[a] || !b_loaded[a]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Loads whatever a run of side n would read that is still unwritten.
   task automatic fill_missing(input int n);
      for (int a = 0; a < n*n; a++) begin
         if (!a_loaded[a]) queue_load(OP_LOAD_A, a, random_word());
         if (!b_loaded[a]) queue_load(OP_LOAD_B, a, random_word());
      end
   endtask

   // Holds the sender until all results are in and the block has settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || expected_products.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the side length register while the block is idle.
   task automatic set_dimension(input logic [DIM_W-1:0] dim);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= dim;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_dimension = dim;
      @(negedge clock);
   endtask

   // Request driver: presents queued transactions and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_products(req_op, req_element_index, req_element_value);
         end
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_request = queued_requests.pop_front();
               req_valid <= 1'b1;
               req_op <= next_request.op;
               req_element_index <= next_request.index;
               req_element_value <= next_request.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted transaction against the oldest expected product.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_products.size() == 0) begin
               $error("product at index %0d arrived with nothing expected", rsp_product_index);
               mismatches++;
            end else begin
               wanted_product = expected_products.pop_front();
               if (rsp_product_index !== wanted_product.index) begin
                  $error("product_index expected %0d, got %0d",
                         wanted_product.index, rsp_product_index);
                  mismatches++;
               end
               if (rsp_product_value !== wanted_product.value) begin
                  $error("product_value expected %0d, got %0d",
                         $signed(wanted_product.value), rsp_product_value);
                  mismatches++;
               end
               if (rsp_last !== wanted_product.last) begin
                  $error("last expected %0d, got %0d", wanted_product.last, rsp_last);
                  mismatches++;
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: a long stretch without any transaction means the block hung.
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("square_int32_matrix_multiply_test failed");
      $finish;
   end

   // Stimulus sequence: directed cases first, then random phases per side length.
   initial begin
      int plan_pos;
      int count;
      int pick;
      int n;
      int addr;
      dim_plan = '{3, 15, 0, 8, 2, 9, 5, 1, 4, 7, 6, 12, 14, 3};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Side one: wrapping products of the signed extremes.
      set_dimension(4'd1);
      queue_load(OP_LOAD_A, 0, 32'h8000_0000);
      queue_load(OP_LOAD_B, 0, 32'hffff_ffff);
      queue_run();
      queue_load(OP_LOAD_A, 0, 32'h7fff_ffff);
      queue_load(OP_LOAD_B, 0, 32'h7fff_ffff);
      queue_run();
      // An unused opcode changes nothing, and loads outside the active square leave the result unchanged.
      queue_unused();
      queue_load(OP_LOAD_A, STORE_DEPTH-1, 32'hffff_ffff);
      queue_load(OP_LOAD_B, STORE_DEPTH-1, 32'h8000_0000);
      queue_run();
      wait_drained();

      // A zero side length behaves as side one.
      set_dimension(4'd0);
      queue_run();
      wait_drained();

      // Side two with the signed extremes, zero and one as operands.
      set_dimension(4'd2);
      queue_load(OP_LOAD_A, 0, 32'h8000_0000);
      queue_load(OP_LOAD_A, 1, 32'h7fff_ffff);
      queue_load(OP_LOAD_A, 2, 32'hffff_ffff);
      queue_load(OP_LOAD_A, 3, 32'h0000_0000);
      queue_load(OP_LOAD_B, 0, 32'h7fff_ffff);
      queue_load(OP_LOAD_B, 1, 32'h8000_0000);
      queue_load(OP_LOAD_B, 2, 32'h0000_0001);
      queue_load(OP_LOAD_B, 3, 32'hffff_ffff);
      queue_run();
      wait_drained();

      // Random phases: mostly loads inside the square and runs, some noise.
      plan_pos = 0;
      while (items_issued < ITEM_TARGET) begin
         set_dimension(DIM_W'(dim_plan[plan_pos % PLAN_LENGTH]));
         n = side_of(active_dimension);
         // The phase with side length 15 runs with both sides never idling.
         steady = (active_dimension == 4'd15);
         count = $urandom_range(10, 28);
         repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               queue_unused();
            end else if (pick < 22 && operands_ready(n)) begin
               queue_run();
            end else begin
               addr = ($urandom_range(99) < 80) ? $urandom_range(n*n-1) : $urandom_range(63);
               queue_load($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A, addr, random_word());
            end
         end
         fill_missing(n);
         queue_run();
         wait_drained();
         steady = 1'b0;
         plan_pos++;
      end

      if (mismatches == 0) begin
         $display("square_int32_matrix_multiply_test passed");
      end else begin
         $display("square_int32_matrix_multiply_test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/smm_pkg.sv
hw/rtl/smm_ctrl.sv
hw/rtl/smm_datapath.sv
hw/rtl/square_int32_matrix_multiply.sv
bench/square_int32_matrix_multiply_test.sv
